// File: hw/rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// shared constants and types for the stack with lazy bottom-k increment
// ----------------------------------------------------------------------------
package isl_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the ports
  localparam int CAP_W   = 11;
  localparam int MODE_W  = 2;
  localparam int OPER_W  = 32;
  localparam int COUNT_W = 16;
  localparam int OUT_W   = 32;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_INC  = 2'd2
  } mode_t;

endpackage

// File: hw/rtl/increment_stack_lazy.sv
// ----------------------------------------------------------------------------
// increment_stack_lazy
// bounded stack of signed values with a constant-time add to the bottom k
// entries, kept as a pending-increment ram beside the value ram
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, mode, operand_value,  | in
//           | count                                     |
//  result   | out_valid, out_ready, popped_value,       | out
//           | was_empty                                 |
//  config   | cfg_valid, cfg_ready, cfg_data (capacity) | in
//
//  push and the unused mode finish at accept, where a push writes both rams;
//  pop reads the rams at accept and writes the pending entry below back in
//  the pop state, where it waits while the result register is still full;
//  an increment with something to add reads at accept and adds in the
//  increment state; one with a zero count or an empty stack finishes at accept
//  reset clears the fill level and the result valid flag and sets state and
//  capacity to reset values; the rams need no clearing pass since an entry
//  is only read after a push wrote it; config transactions are always taken
//  (cfg_ready is tied high)
module increment_stack_lazy #(
  parameter int DEPTH      = isl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [isl_pkg::MODE_W-1:0]       mode,
  input  logic signed [isl_pkg::OPER_W-1:0] operand_value,
  input  logic [isl_pkg::COUNT_W-1:0]      count,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [isl_pkg::OUT_W-1:0] popped_value,
  output logic                             was_empty,
  // config channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [isl_pkg::CAP_W-1:0]        cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  // compare widths wide enough for both sides
  localparam int CW = (FW > isl_pkg::CAP_W) ? FW : isl_pkg::CAP_W;
  localparam int KW = (FW > isl_pkg::COUNT_W) ? FW : isl_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_INC  = 3'b100
  } state_t;

  state_t                      state, state_next;
  logic [FW-1:0]               fill_level, fill_level_next;
  logic [isl_pkg::CAP_W-1:0]   capacity;
  logic [AW-1:0]               op_addr, op_addr_next;
  logic [DATA_WIDTH-1:0]       op_amount, op_amount_next;
  logic                        op_below, op_below_next;
  logic                        op_empty, op_empty_next;
  logic                        out_valid_next;
  logic [isl_pkg::OUT_W-1:0]   out_data, out_data_next;
  logic                        out_empty, out_empty_next;

  // decoded input
  logic                        in_accept;
  logic                        is_push, is_pop, is_inc;
  logic [DATA_WIDTH-1:0]       operand_ext;

  // limit and clamping
  logic [CW-1:0]               cap_ext, limit;
  logic                        push_ok;
  logic [KW-1:0]               count_ext, fill_ext, k_clamp, k_minus1;
  logic [FW-1:0]               fill_minus1;

  // ram ports
  logic [AW-1:0]               rd_addr_a, rd_addr_b, live_addr;
  logic                        val_we, pend_we;
  logic [AW-1:0]               pend_wr_addr;
  logic [DATA_WIDTH-1:0]       pend_wr_data;
  logic [DATA_WIDTH-1:0]       val_rd, pend_rd_a, pend_rd_b;
  logic                        pop_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  assign is_push = (mode == isl_pkg::MODE_PUSH);
  assign is_pop  = (mode == isl_pkg::MODE_POP);
  assign is_inc  = (mode == isl_pkg::MODE_INC);

  // sign-extend or truncate the operand to the stored width
  assign operand_ext = DATA_WIDTH'(operand_value);

  // stack limit is min(capacity, DEPTH)
  assign cap_ext = CW'(capacity);
  assign limit   = (cap_ext < CW'(DEPTH)) ? cap_ext : CW'(DEPTH);
  assign push_ok = CW'(fill_level) < limit;

  // increment target is entry min(count, fill) - 1
  assign count_ext = KW'(count);
  assign fill_ext  = KW'(fill_level);
  assign k_clamp   = (count_ext < fill_ext) ? count_ext : fill_ext;
  assign k_minus1  = k_clamp - KW'(1);

  assign fill_minus1 = fill_level - FW'(1);

  // read address for the item being presented, held from a register while busy
  assign live_addr = is_pop ? fill_minus1[AW-1:0] : k_minus1[AW-1:0];
  assign rd_addr_a = (state == ST_IDLE) ? live_addr : op_addr;
  assign rd_addr_b = rd_addr_a - AW'(1);

  // pop finishes once the result register can take the new result
  assign pop_done = (state == ST_POP) && (!out_valid || out_ready);

  // value ram only written by push
  assign val_we = in_accept && is_push && push_ok;

  // pending ram: zero on push, carry-down on pop, add on increment
  always_comb begin
    pend_we      = 1'b0;
    pend_wr_addr = fill_level[AW-1:0];
    pend_wr_data = '0;
    if (val_we) begin
      pend_we = 1'b1;
    end else if (pop_done && !op_empty && op_below) begin
      pend_we      = 1'b1;
      pend_wr_addr = op_addr - AW'(1);
      pend_wr_data = pend_rd_b + pend_rd_a;
    end else if (state == ST_INC) begin
      pend_we      = 1'b1;
      pend_wr_addr = op_addr;
      pend_wr_data = pend_rd_a + op_amount;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    fill_level_next = fill_level;
    op_addr_next    = op_addr;
    op_amount_next  = op_amount;
    op_below_next   = op_below;
    op_empty_next   = op_empty;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    out_empty_next  = out_empty;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op_addr_next   = live_addr;
          op_amount_next = operand_ext;
          if (is_push) begin
            if (push_ok) begin
              fill_level_next = fill_level + FW'(1);
            end
          end else if (is_pop) begin
            state_next    = ST_POP;
            op_empty_next = (fill_level == '0);
            op_below_next = (fill_level > FW'(1));
            if (fill_level != '0) begin
              fill_level_next = fill_minus1;
            end
          end else if (is_inc) begin
            // nothing to do for an empty stack or a zero count
            if (k_clamp != '0) begin
              state_next = ST_INC;
            end
          end
        end
      end
      ST_POP: begin
        if (pop_done) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
          out_empty_next = op_empty;
          out_data_next  = op_empty ? '1 : isl_pkg::OUT_W'(val_rd + pend_rd_a);
        end
      end
      ST_INC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_level <= '0;
      capacity   <= isl_pkg::CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_level <= fill_level_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_addr   <= op_addr_next;
    op_amount <= op_amount_next;
    op_below  <= op_below_next;
    op_empty  <= op_empty_next;
    out_data  <= out_data_next;
    out_empty <= out_empty_next;
  end

  assign popped_value = out_data;
  assign was_empty    = out_empty;

  // stored values
  isl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk       (clk),
    .we        (val_we),
    .wr_addr   (fill_level[AW-1:0]),
    .wr_data   (operand_ext),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (val_rd),
    .rd_data_b ()
  );

  // pending increments, second port reads the entry below the one addressed
  isl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_pending_ram (
    .clk       (clk),
    .we        (pend_we),
    .wr_addr   (pend_wr_addr),
    .wr_data   (pend_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (pend_rd_a),
    .rd_data_b (pend_rd_b)
  );

`ifndef NO_ASSERTIONS
  // fill level stays within the ram
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FW'(DEPTH))
    else $error("fill level beyond depth");

  // a waiting result is never overwritten by a pop
  a_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) && out_valid && !out_ready |=> (state == ST_POP))
    else $error("pop completed over a pending result");

  // a result only appears at the end of a pop
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_POP))
    else $error("result without a pop");

  // a refused push leaves the fill level alone
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    in_accept && is_push && !push_ok |=> $stable(fill_level))
    else $error("push taken on a full stack");

  // a push writes value and pending increment of the same entry
  a_push_pair: assert property (@(posedge clk) disable iff (rst)
    val_we |-> pend_we && (pend_wr_addr == fill_level[AW-1:0]) && (pend_wr_data == '0))
    else $error("push wrote mismatched pending entry");
`endif

endmodule

// File: hw/rtl/isl_ram.sv
// ----------------------------------------------------------------------------
// isl_ram
// generic synchronous ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int WIDTH = isl_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = isl_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
